/* rtl/core/pfx_pkg.sv */
package pfx_pkg;

    localparam int BYTE_W = 8;
    localparam int CAP_W  = 9;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 9'd240;

    // Tag byte layout: field number in bits 7:3, wire type in bits 2:0
    localparam logic [4:0] FIELD_PORT = 5'd1;
    localparam logic [4:0] FIELD_TEXT = 5'd2;
    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_LEN     = 3'd2;
    localparam logic [BYTE_W-1:0] PORT_TEXT = 8'd1;

    // tuser bit positions on the result side
    localparam int USER_VALID    = 0;
    localparam int USER_COMPLETE = 1;
    localparam int USER_FOUND    = 2;
    localparam int USER_W        = 3;

    typedef enum logic [5:0] {
        PH_TAG  = 6'b000001,
        PH_PORT = 6'b000010,
        PH_LEN  = 6'b000100,
        PH_TEXT = 6'b001000,
        PH_SKIP = 6'b010000,
        PH_STOP = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              last_byte;
    } t_beat;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              text_byte_valid;
        logic              text_complete;
        logic              packet_end;
        logic              text_found;
    } t_result;

endpackage

/* rtl/core/protobuf_text_field_extractor_core.sv */
// Picks a text payload out of a decrypted packet payload, one byte per beat.
// Each input beat carries one payload byte, with tlast on the final byte of
// the packet. Every input beat yields exactly one result beat: the byte
// itself when it belongs to an accepted text (zero otherwise), and flags in
// tuser for "text byte", "last byte of the announced text" and, on the
// packet's last beat, "a complete text was found". A tag 0x08 (field 1,
// varint) takes the next byte as the port; a tag 0x12 (field 2,
// length-delimited) takes the next byte as a length. The text is accepted
// when the port is 1 and the length is nonzero and below the capacity
// register; otherwise those bytes are skipped. Any other tag, or a complete
// text, stops parsing until packet end. Parse state clears after each
// packet's last byte; the capacity register keeps its value (240 after
// reset); the user must write it only while the block is idle, which the
// block itself does not enforce. Throughput is one beat per clock while
// the result side does not stall; a beat passes the input register, then
// the parse state machine feeding the result register. The next byte's
// parse depends only on the registered parse state; no stall is inserted.
module protobuf_text_field_extractor_core
    import pfx_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration: text capacity
    input  logic              i_cfg_we,
    input  logic [CAP_W-1:0]  i_cfg_wdata,
    // payload bytes in
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [BYTE_W-1:0] i_s_axis_tdata,   // [7:0] payload_byte
    input  logic              i_s_axis_tlast,   // last_byte
    // results out
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [BYTE_W-1:0] o_m_axis_tdata,   // [7:0] text_byte
    output logic [USER_W-1:0] o_m_axis_tuser,   // [0] text_byte_valid, [1] text_complete,
                                                // [2] text_found
    output logic              o_m_axis_tlast    // packet_end
);

    t_beat   in_beat, stage_beat;
    logic    stage_valid;
    logic    out_ready;
    logic    take;
    t_result parse_result, out_result;

    assign in_beat.payload_byte = i_s_axis_tdata;
    assign in_beat.last_byte    = i_s_axis_tlast;

    // advance the input register whenever the result register has room
    assign take = stage_valid && out_ready;

    pfx_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_beat    (in_beat),
        .i_advance (out_ready),
        .o_ready   (o_s_axis_tready),
        .o_valid   (stage_valid),
        .o_beat    (stage_beat)
    );

    // parse state only moves on a beat that really goes to the result register
    pfx_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (take),
        .i_beat      (stage_beat),
        .o_result    (parse_result)
    );

    pfx_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (stage_valid),
        .i_result (parse_result),
        .i_ready  (i_m_axis_tready),
        .o_ready  (out_ready),
        .o_valid  (o_m_axis_tvalid),
        .o_result (out_result)
    );

    assign o_m_axis_tdata                = out_result.text_byte;
    assign o_m_axis_tuser[USER_VALID]    = out_result.text_byte_valid;
    assign o_m_axis_tuser[USER_COMPLETE] = out_result.text_complete;
    assign o_m_axis_tuser[USER_FOUND]    = out_result.text_found;
    assign o_m_axis_tlast                = out_result.packet_end;

endmodule

/* rtl/core/pfx_in_reg.sv */
module pfx_in_reg
    import pfx_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_beat i_beat,
    input  logic  i_advance,
    output logic  o_ready,
    output logic  o_valid,
    output t_beat o_beat
);

    logic  r_valid;
    t_beat r_beat;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // hold the byte until the parser takes it
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end

endmodule

/* rtl/core/pfx_parser.sv */
module pfx_parser
    import pfx_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    input  logic             i_take,
    input  t_beat            i_beat,
    output t_result          o_result
);

    logic [CAP_W-1:0]  r_capacity;
    t_phase            r_phase, n_phase;
    logic              r_port_one, n_port_one;
    logic [BYTE_W-1:0] r_remain, n_remain;
    logic              r_found, n_found;

    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] remain_dec;
    logic              tv, tc;

    assign b          = i_beat.payload_byte;
    assign remain_dec = r_remain - 8'd1;

    always_comb begin
        n_phase    = r_phase;
        n_port_one = r_port_one;
        n_remain   = r_remain;
        n_found    = r_found;
        tv         = 1'b0;
        tc         = 1'b0;
        case (r_phase)
            PH_TAG: begin
                if (b[7:3] == FIELD_PORT && b[2:0] == WT_VARINT) begin
                    n_phase = PH_PORT;
                end else if (b[7:3] == FIELD_TEXT && b[2:0] == WT_LEN) begin
                    n_phase = PH_LEN;
                end else begin
                    n_phase = PH_STOP;
                end
            end
            PH_PORT: begin
                n_port_one = (b == PORT_TEXT);
                n_phase    = PH_TAG;
            end
            PH_LEN: begin
                if (r_port_one && b != '0 && {1'b0, b} < r_capacity) begin
                    n_remain = b;
                    n_phase  = PH_TEXT;
                end else if (b == '0) begin
                    n_phase = PH_TAG;
                end else begin
                    n_remain = b;
                    n_phase  = PH_SKIP;
                end
            end
            PH_TEXT: begin
                tv       = 1'b1;
                n_remain = remain_dec;
                if (remain_dec == '0) begin
                    tc      = 1'b1;
                    n_found = 1'b1;
                    n_phase = PH_STOP;
                end
            end
            PH_SKIP: begin
                n_remain = remain_dec;
                if (remain_dec == '0) begin
                    n_phase = PH_TAG;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result.text_byte       = tv ? b : '0;
    assign o_result.text_byte_valid = tv;
    assign o_result.text_complete   = tc;
    assign o_result.packet_end      = i_beat.last_byte;
    assign o_result.text_found      = i_beat.last_byte && n_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    // each packet parses on its own: drop all parse state after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_beat.last_byte)) begin
            r_phase    <= PH_TAG;
            r_port_one <= 1'b0;
            r_remain   <= '0;
            r_found    <= 1'b0;
        end else if (i_take) begin
            r_phase    <= n_phase;
            r_port_one <= n_port_one;
            r_remain   <= n_remain;
            r_found    <= n_found;
        end
    end

endmodule

/* rtl/core/pfx_out_reg.sv */
module pfx_out_reg
    import pfx_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

/* rtl/core/pfx_checker.sv */
module pfx_checker
    import pfx_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_m_axis_tvalid,
    input logic              i_m_axis_tready,
    input logic [BYTE_W-1:0] o_m_axis_tdata,
    input logic [USER_W-1:0] o_m_axis_tuser,
    input logic              o_m_axis_tlast
);

    // a stalled result beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("result beat changed while stalled");

    a_found_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[USER_FOUND] |-> o_m_axis_tlast)
        else $error("text_found outside packet end");

    a_complete_is_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[USER_COMPLETE] |-> o_m_axis_tuser[USER_VALID])
        else $error("text_complete on a non-text byte");

    a_zero_when_not_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[USER_VALID] |-> o_m_axis_tdata == '0)
        else $error("nonzero data on a non-text byte");

endmodule

bind protobuf_text_field_extractor_core pfx_checker u_pfx_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
